// ===== src/kmsog_pkg.sv =====
package kmsog_pkg;

  localparam int GRID_DIM_DEF   = 256;
  localparam int KERNEL_MAX_DEF = 16;
  localparam int DATA_W         = 8;
  // signed width of a stamped grid position: row + kernel row - offset
  localparam int POS_W          = 10;

  localparam logic [1:0] FUNC_GRID_WR = 2'd0;
  localparam logic [1:0] FUNC_KERN_WR = 2'd1;
  localparam logic [1:0] FUNC_STAMP   = 2'd2;
  localparam logic [1:0] FUNC_GRID_RD = 2'd3;

  localparam logic [1:0] REG_KERNEL_ROWS = 2'd0;
  localparam logic [1:0] REG_KERNEL_COLS = 2'd1;
  localparam logic [1:0] REG_GRID_ROWS   = 2'd2;
  localparam logic [1:0] REG_GRID_COLS   = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_RESP,
    ST_STAMP,
    ST_DRAIN
  } state_t;

endpackage

// ===== src/kmsog_ram.sv =====
module kmsog_ram #(
  parameter int WIDTH = kmsog_pkg::DATA_W,
  parameter int DEPTH = kmsog_pkg::KERNEL_MAX_DEF * kmsog_pkg::KERNEL_MAX_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/kernel_min_stamp_on_grid_top.sv =====
// channel   direction  handshake                    payload
// request   in         start && !busy               func, row, col, value
// result    out        done (one cycle, no stall)   read_value, done_func
// config    in         cfg_valid && cfg_ready       cfg_index, cfg_data
//
// grid write, kernel write and grid read: busy through ST_ACCESS and ST_RESP, done in the cycle after
// stamp: busy through ST_STAMP, then ST_DRAIN (kr, kc the kernel size in use, capped at KERNEL_MAX),
// with one read-modify-write per covered cell of the kr x kc kernel through the grid memory port
// an empty kernel stamp goes straight from ST_IDLE to ST_DRAIN
// reset clears control and restores the size registers; grid and kernel memories hold nothing until written
// results cannot be stalled; cfg_ready is always high
module kernel_min_stamp_on_grid_top #(
  parameter int GRID_DIM   = kmsog_pkg::GRID_DIM_DEF,
  parameter int KERNEL_MAX = kmsog_pkg::KERNEL_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] func,
  input  logic [7:0] row,
  input  logic [7:0] col,
  input  logic [7:0] value,
  output logic       done,
  output logic [7:0] read_value,
  output logic [1:0] done_func,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data
);

  localparam int GDEPTH = GRID_DIM * GRID_DIM;
  localparam int GA_W   = (GDEPTH > 1) ? $clog2(GDEPTH) : 1;
  localparam int KDEPTH = KERNEL_MAX * KERNEL_MAX;
  localparam int KA_W   = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;
  localparam int KC_W   = $clog2(KERNEL_MAX + 1);
  localparam int GD_W   = $clog2(GRID_DIM + 1);
  localparam int POS_W  = kmsog_pkg::POS_W;

  kmsog_pkg::state_t state, state_next;

  logic [4:0] kernel_rows, kernel_cols;
  logic [8:0] grid_rows, grid_cols;

  logic [1:0] it_func;
  logic [7:0] it_row, it_col, it_value;
  logic [KC_W-1:0] ki, kj;
  logic            p_vld;
  logic [GA_W-1:0] p_addr;

  logic [KC_W-1:0] kr_eff, kc_eff, kr_m1, kc_m1, off;
  logic [GD_W-1:0] gr_eff, gc_eff;
  logic signed [POS_W-1:0] gi, gj;
  logic            cell_ok, last_cell, acc_ok, kw_ok, accept;
  logic [GA_W-1:0] stamp_addr, acc_addr;
  logic [KA_W-1:0] kern_addr, kw_addr;

  logic            g_we, k_we, fin;
  logic [GA_W-1:0] g_waddr, g_raddr;
  logic [KA_W-1:0] k_waddr, k_raddr;
  logic [7:0]      g_wdata, k_wdata, g_rdata, k_rdata;

  assign accept    = start && !busy;
  assign busy      = (state != kmsog_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  // effective sizes
  assign kr_eff = (32'(kernel_rows) > 32'(KERNEL_MAX)) ? KC_W'(KERNEL_MAX) : KC_W'(kernel_rows);
  assign kc_eff = (32'(kernel_cols) > 32'(KERNEL_MAX)) ? KC_W'(KERNEL_MAX) : KC_W'(kernel_cols);
  assign gr_eff = (32'(grid_rows) > 32'(GRID_DIM)) ? GD_W'(GRID_DIM) : GD_W'(grid_rows);
  assign gc_eff = (32'(grid_cols) > 32'(GRID_DIM)) ? GD_W'(GRID_DIM) : GD_W'(grid_cols);
  assign kr_m1  = kr_eff - KC_W'(1);
  assign kc_m1  = kc_eff - KC_W'(1);
  assign off    = (kr_eff == '0) ? '0 : (kr_m1 >> 1);

  // stamped cell position
  assign gi = $signed(POS_W'(it_row)) + $signed(POS_W'(ki)) - $signed(POS_W'(off));
  assign gj = $signed(POS_W'(it_col)) + $signed(POS_W'(kj)) - $signed(POS_W'(off));
  assign cell_ok = !gi[POS_W-1] && !gj[POS_W-1]
                   && (32'($unsigned(gi)) < 32'(gr_eff))
                   && (32'($unsigned(gj)) < 32'(gc_eff));
  assign last_cell  = (ki == kr_m1) && (kj == kc_m1);
  assign stamp_addr = GA_W'(GA_W'($unsigned(gi)) * GA_W'(GRID_DIM)) + GA_W'($unsigned(gj));
  assign kern_addr  = KA_W'(KA_W'(ki) * KA_W'(KERNEL_MAX)) + KA_W'(kj);

  // single cell access
  assign acc_ok   = (32'(it_row) < 32'(GRID_DIM)) && (32'(it_col) < 32'(GRID_DIM));
  assign kw_ok    = (32'(it_row) < 32'(KERNEL_MAX)) && (32'(it_col) < 32'(KERNEL_MAX));
  assign acc_addr = GA_W'(GA_W'(it_row) * GA_W'(GRID_DIM)) + GA_W'(it_col);
  assign kw_addr  = KA_W'(KA_W'(it_row) * KA_W'(KERNEL_MAX)) + KA_W'(it_col);

  always_comb begin
    state_next = state;
    case (state)
      kmsog_pkg::ST_IDLE: begin
        if (start) begin
          if (func == kmsog_pkg::FUNC_STAMP) begin
            state_next = ((kr_eff == '0) || (kc_eff == '0)) ?
                         kmsog_pkg::ST_DRAIN : kmsog_pkg::ST_STAMP;
          end else begin
            state_next = kmsog_pkg::ST_ACCESS;
          end
        end
      end
      kmsog_pkg::ST_ACCESS: state_next = kmsog_pkg::ST_RESP;
      kmsog_pkg::ST_RESP:   state_next = kmsog_pkg::ST_IDLE;
      kmsog_pkg::ST_STAMP: begin
        if (last_cell) begin
          state_next = kmsog_pkg::ST_DRAIN;
        end
      end
      kmsog_pkg::ST_DRAIN:  state_next = kmsog_pkg::ST_IDLE;
      default:              state_next = kmsog_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    g_we    = 1'b0;
    g_waddr = p_addr;
    g_wdata = k_rdata;
    g_raddr = stamp_addr;
    k_we    = 1'b0;
    k_waddr = kw_addr;
    k_wdata = it_value;
    k_raddr = kern_addr;
    fin     = 1'b0;
    case (state)
      kmsog_pkg::ST_ACCESS: begin
        g_raddr = acc_addr;
        if (it_func == kmsog_pkg::FUNC_GRID_WR) begin
          g_we    = acc_ok;
          g_waddr = acc_addr;
          g_wdata = it_value;
        end
        if (it_func == kmsog_pkg::FUNC_KERN_WR) begin
          k_we = kw_ok;
        end
      end
      kmsog_pkg::ST_RESP: fin = 1'b1;
      kmsog_pkg::ST_STAMP: g_we = p_vld && (k_rdata < g_rdata);
      kmsog_pkg::ST_DRAIN: begin
        g_we = p_vld && (k_rdata < g_rdata);
        fin  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= kmsog_pkg::ST_IDLE;
      kernel_rows <= 5'd1;
      kernel_cols <= 5'd1;
      grid_rows   <= 9'd256;
      grid_cols   <= 9'd256;
      p_vld       <= 1'b0;
      done        <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          kmsog_pkg::REG_KERNEL_ROWS: kernel_rows <= cfg_data[4:0];
          kmsog_pkg::REG_KERNEL_COLS: kernel_cols <= cfg_data[4:0];
          kmsog_pkg::REG_GRID_ROWS:   grid_rows   <= cfg_data;
          kmsog_pkg::REG_GRID_COLS:   grid_cols   <= cfg_data;
          default: ;
        endcase
      end
      p_vld <= (state == kmsog_pkg::ST_STAMP) && cell_ok;
      done  <= fin;
    end
  end

  always_ff @(posedge clk) begin
    p_addr <= stamp_addr;
    if (accept) begin
      it_func  <= func;
      it_row   <= row;
      it_col   <= col;
      it_value <= value;
      ki       <= '0;
      kj       <= '0;
    end else if (state == kmsog_pkg::ST_STAMP) begin
      if (kj == kc_m1) begin
        kj <= '0;
        ki <= ki + KC_W'(1);
      end else begin
        kj <= kj + KC_W'(1);
      end
    end
    if (fin) begin
      done_func  <= it_func;
      read_value <= ((it_func == kmsog_pkg::FUNC_GRID_RD) && acc_ok) ? g_rdata : 8'd0;
    end
  end

  kmsog_ram #(
    .WIDTH (kmsog_pkg::DATA_W),
    .DEPTH (GDEPTH)
  ) u_grid_ram (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .raddr (g_raddr),
    .rdata (g_rdata)
  );

  kmsog_ram #(
    .WIDTH (kmsog_pkg::DATA_W),
    .DEPTH (KDEPTH)
  ) u_kern_ram (
    .clk   (clk),
    .we    (k_we),
    .waddr (k_waddr),
    .wdata (k_wdata),
    .raddr (k_raddr),
    .rdata (k_rdata)
  );

endmodule

// ===== src/kmsog_chk.sv =====
module kmsog_chk (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [1:0] done_func,
  input logic [7:0] read_value
);

  // a result only shows once the request has finished
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while busy");

  // every request ends in exactly one result
  a_fell_done: assert property (@(posedge clk) disable iff (rst) $fell(busy) |-> done)
    else $error("request finished without a result");

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  // only grid reads carry data
  a_zero_value: assert property (@(posedge clk) disable iff (rst)
    (done && (done_func != kmsog_pkg::FUNC_GRID_RD)) |-> (read_value == 8'd0))
    else $error("nonzero read_value on a non-read result");

endmodule

bind kernel_min_stamp_on_grid_top kmsog_chk u_kmsog_chk (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .done_func  (done_func),
  .read_value (read_value)
);
